// ----- hdl/vdc_pkg.sv -----
// Package for the voxel density clustering block: widths, defaults, state codes.
// No dependencies.
`timescale 1ns / 1ps
package vdc_pkg;
  localparam int MaxVoxelsDefault = 64;
  localparam int CoordBitsDefault = 8;
  localparam int MinW  = 7;
  localparam int DistW = 18;
  localparam int IdxW  = 6;
  localparam int CntW  = 7;
  localparam int InW   = 8;
  localparam logic [MinW-1:0]  MinReset  = 7'd1;
  localparam logic [DistW-1:0] DistReset = 18'd4;

  typedef enum logic [0:0] {
    REG_MIN_NEIGHBORS = 1'b0,
    REG_MAX_DIST_SQ   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEED,
    ST_SCAN,
    ST_PUSH,
    ST_EMIT
  } state_t;

  // One queued command from front to back: an accepted voxel.
  typedef struct packed {
    logic [InW-1:0] x;
    logic [InW-1:0] y;
    logic [InW-1:0] z;
    logic           final_voxel;
  } vox_cmd_t;
endpackage

// ----- hdl/vdc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/vdc_front.sv -----
// Front end: takes voxel transactions into a short command queue.
// Depends on vdc_pkg.
`timescale 1ns / 1ps
module vdc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vdc_pkg::vox_cmd_t cmd_in,
  output logic              cmd_valid,
  output vdc_pkg::vox_cmd_t cmd_out,
  input  logic              cmd_pop,
  input  logic              back_busy
);
  import vdc_pkg::*;

  vox_cmd_t q [2];
  logic     wr_ptr;
  logic     rd_ptr;
  logic [1:0] fill;
  logic     push;
  logic     final_pending;

  // Hold off new voxels while the queue is full, a set is clustering or a final voxel is queued
  assign busy = (fill == 2'd2) || back_busy || final_pending;
  assign push = start && !busy;
  assign cmd_valid = (fill != 2'd0);
  assign cmd_out = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
      final_pending <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, cmd_pop};
      if (push && cmd_in.final_voxel) begin
        final_pending <= 1'b1;
      end else if (cmd_pop && cmd_out.final_voxel) begin
        final_pending <= 1'b0;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |-> !push) else $error("queue overfill");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("bad fill");
endmodule

// ----- hdl/vdc_back.sv -----
// Back end: stores voxels, runs the seed/scan/push clustering sequencer, emits labels.
// Depends on vdc_pkg and vdc_ram.
`timescale 1ns / 1ps
module vdc_back #(
  parameter int MaxVoxels = vdc_pkg::MaxVoxelsDefault,
  parameter int CoordBits = vdc_pkg::CoordBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  vdc_pkg::vox_cmd_t         cmd,
  output logic                      cmd_pop,
  output logic                      back_busy,
  input  logic [vdc_pkg::MinW-1:0]  min_neighbors,
  input  logic [vdc_pkg::DistW-1:0] max_distance_squared,
  output logic                      done,
  output logic [vdc_pkg::IdxW-1:0]  voxel_index,
  output logic [vdc_pkg::IdxW-1:0]  cluster_id,
  output logic [vdc_pkg::CntW-1:0]  cluster_count,
  output logic                      overflow,
  output logic                      last_result
);
  import vdc_pkg::*;

  localparam int AW = $clog2(MaxVoxels);
  localparam int NW = $clog2(MaxVoxels + 1);
  localparam int CW = 3 * CoordBits;
  localparam int SqW = 2 * CoordBits + 2;
  localparam int CmpW = (SqW > DistW) ? SqW : DistW;

  state_t state, state_next;

  logic [NW-1:0] n;
  logic          ovf;
  logic [MaxVoxels-1:0] assigned;
  logic [MaxVoxels-1:0] marks;
  logic [AW-1:0] q_head;
  logic [NW-1:0] q_len;
  logic [CntW-1:0] next_id;
  logic [NW-1:0] clustered;
  logic [AW-1:0] origin;
  logic [CW-1:0] origin_c;
  logic [NW-1:0] j;
  logic          rd_ok;
  logic [NW-1:0] cnt;
  logic [MaxVoxels-1:0] cand;
  logic [NW-1:0] pj;
  logic [NW-1:0] ei;
  logic          lat;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  logic          q_we;
  logic [AW-1:0] q_waddr;
  logic [AW-1:0] q_wdata;
  logic [AW-1:0] q_rdata;

  logic            lab_we;
  logic [AW-1:0]   lab_waddr;
  logic [IdxW-1:0] lab_wdata;
  logic [AW-1:0]   lab_raddr;
  logic [IdxW-1:0] lab_rdata;

  logic [AW-1:0] seed_idx;
  logic          seed_found;
  logic [SqW-1:0] d2;
  logic          near;

  logic          seed_go;
  logic          is_core;
  logic          cand_push;
  logic          push_end;
  logic          origin_take;

  vdc_ram #(.Width(CW), .Depth(1 << AW)) u_coords (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata));

  // Pending origin queue; the head entry is held on the read data
  vdc_ram #(.Width(AW), .Depth(1 << AW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_head), .rdata(q_rdata));

  // Cluster labels
  vdc_ram #(.Width(IdxW), .Depth(1 << AW)) u_labels (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata));

  // Load port
  assign cmd_pop   = (state == ST_LOAD) && cmd_valid;
  assign ram_we    = cmd_pop && (n < NW'(MaxVoxels));
  assign ram_waddr = n[AW-1:0];
  assign ram_wdata = {CoordBits'(cmd.z), CoordBits'(cmd.y), CoordBits'(cmd.x)};
  assign back_busy = (state != ST_LOAD);

  // Current origin is the queue head
  assign origin = q_rdata;

  // Read address: origin fetch at scan start, then sweep j
  assign ram_raddr = (state == ST_SCAN && lat) ? j[AW-1:0] : origin;

  // Sequencer events
  assign seed_go = (state == ST_SEED) && (q_len == '0) && (clustered < n) && seed_found;
  assign is_core = (cnt >= NW'(min_neighbors)) &&
                   ({1'b0, min_neighbors} <= {1'b0, CntW'(MaxVoxels)});
  assign cand_push = (state == ST_PUSH) && (pj < n) && cand[pj[AW-1:0]] && is_core;
  assign push_end = (state == ST_PUSH) && (pj >= n);
  assign origin_take = push_end && is_core && !assigned[origin];

  // Queue append at the tail
  assign q_we    = seed_go || cand_push;
  assign q_waddr = AW'(q_head + q_len[AW-1:0]);
  assign q_wdata = seed_go ? seed_idx : pj[AW-1:0];

  // Label writes: new seed or a core origin joining the current cluster
  always_comb begin
    lab_we = 1'b0;
    lab_waddr = seed_idx;
    lab_wdata = next_id[IdxW-1:0];
    if (seed_go) begin
      lab_we = 1'b1;
    end else if (origin_take) begin
      lab_we = 1'b1;
      lab_waddr = origin;
      lab_wdata = IdxW'(next_id - 1'b1);
    end
  end

  // Label read runs one ahead of the emitted index
  assign lab_raddr = (state == ST_EMIT) ? AW'(ei + 1'b1) : ei[AW-1:0];

  // Lowest unassigned stored voxel
  always_comb begin
    seed_idx = '0;
    seed_found = 1'b0;
    for (int k = MaxVoxels - 1; k >= 0; k--) begin
      if (!assigned[k] && NW'(k) < n) begin
        seed_idx = AW'(k);
        seed_found = 1'b1;
      end
    end
  end

  // Squared distance of the registered read against the origin
  always_comb begin
    logic [CoordBits-1:0] a, b, d;
    d2 = '0;
    for (int s = 0; s < 3; s++) begin
      a = origin_c[s*CoordBits +: CoordBits];
      b = ram_rdata[s*CoordBits +: CoordBits];
      d = (a > b) ? a - b : b - a;
      d2 = d2 + SqW'(d) * SqW'(d);
    end
    near = (CmpW'(d2) <= CmpW'(max_distance_squared));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (cmd_pop && cmd.final_voxel) state_next = (n == '0 && ram_we == 1'b0) ?
                 ST_LOAD : ST_SEED;
      ST_SEED: begin
        if (q_len != '0) state_next = ST_SCAN;
        else if (clustered >= n) state_next = ST_EMIT;
      end
      ST_SCAN: if (rd_ok && j >= n) state_next = ST_PUSH;
      ST_PUSH: if (pj >= n) state_next = ST_SEED;
      ST_EMIT: if (ei + 1'b1 >= n) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    done = 1'b0;
    voxel_index = ei[IdxW-1:0];
    cluster_id = lab_rdata;
    cluster_count = next_id;
    overflow = ovf;
    last_result = (ei + 1'b1 == n);
    unique case (state)
      ST_EMIT: done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      n <= '0;
      ovf <= 1'b0;
      assigned <= '0;
      marks <= '0;
      q_head <= '0;
      q_len <= '0;
      next_id <= '0;
      clustered <= '0;
      j <= '0;
      lat <= 1'b0;
      rd_ok <= 1'b0;
      cnt <= '0;
      cand <= '0;
      pj <= '0;
      ei <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          if (cmd_pop) begin
            if (n < NW'(MaxVoxels)) n <= n + 1'b1;
            else ovf <= 1'b1;
          end
          assigned <= '0;
          marks <= '0;
          q_head <= '0;
          q_len <= '0;
          next_id <= '0;
          clustered <= '0;
          ei <= '0;
        end
        ST_SEED: begin
          if (seed_go) begin
            assigned[seed_idx] <= 1'b1;
            next_id <= next_id + 1'b1;
            clustered <= clustered + 1'b1;
            marks[seed_idx] <= 1'b1;
            q_len <= q_len + 1'b1;
          end
          j <= '0;
          lat <= 1'b0;
          rd_ok <= 1'b0;
          cnt <= '0;
          cand <= '0;
        end
        ST_SCAN: begin
          if (!lat) begin
            // origin read issued this cycle
            lat <= 1'b1;
          end else if (!rd_ok) begin
            origin_c <= ram_rdata;
            rd_ok <= 1'b1;
            j <= j + 1'b1;
          end else begin
            // ram_rdata holds voxel j-1
            if (NW'(j - 1'b1) != NW'(origin) && near) begin
              cnt <= cnt + 1'b1;
              if (!assigned[AW'(j - 1'b1)] && !marks[AW'(j - 1'b1)])
                cand[AW'(j - 1'b1)] <= 1'b1;
            end
            if (j < n) j <= j + 1'b1;
          end
          pj <= '0;
        end
        ST_PUSH: begin
          if (pj < n) begin
            if (cand_push) begin
              marks[pj[AW-1:0]] <= 1'b1;
              q_len <= q_len + 1'b1;
            end
            pj <= pj + 1'b1;
          end else begin
            if (origin_take) begin
              assigned[origin] <= 1'b1;
              clustered <= clustered + 1'b1;
            end
            marks[origin] <= 1'b0;
            q_head <= q_head + 1'b1;
            q_len <= q_len - 1'b1;
          end
        end
        ST_EMIT: begin
          ei <= ei + 1'b1;
          if (ei + 1'b1 >= n) begin
            n <= '0;
            ovf <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && ei + 1'b1 < n |=> state == ST_EMIT && ei == $past(ei) + 1'b1)
    else $error("emit order broken");
  a_qlen: assert property (@(posedge clk) disable iff (rst)
    q_len <= NW'(MaxVoxels)) else $error("queue length beyond capacity");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == ST_LOAD) else $error("pop outside load");
endmodule

// ----- hdl/voxel_density_clustering.sv -----
// Top level of the voxel density clustering block: configuration registers,
// front queue and clustering back end. Depends on vdc_pkg, vdc_front, vdc_back.
`timescale 1ns / 1ps
// Voxels are loaded one per start transaction, accepted while busy is low.
// The transaction with final_voxel set closes the set; busy then stays high while
// the sequencer clusters: each queued origin sweeps the coordinate RAM once.
// Afterwards one result per voxel is driven back to back with done high; the
// receiver cannot stall.
module voxel_density_clustering #(
  parameter int MaxVoxels = vdc_pkg::MaxVoxelsDefault,
  parameter int CoordBits = vdc_pkg::CoordBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [7:0] pos_z,
  input  logic       final_voxel,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [17:0] cfg_data,
  output logic       done,
  output logic [5:0] voxel_index,
  output logic [5:0] cluster_id,
  output logic [6:0] cluster_count,
  output logic       overflow,
  output logic       last_result
);
  import vdc_pkg::*;

  logic [MinW-1:0]  min_neighbors;
  logic [DistW-1:0] max_distance_squared;
  vox_cmd_t cmd_in, cmd;
  logic cmd_valid, cmd_pop, back_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_neighbors <= MinReset;
      max_distance_squared <= DistReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_NEIGHBORS: min_neighbors <= cfg_data[MinW-1:0];
        REG_MAX_DIST_SQ:   max_distance_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cmd_in = '{x: pos_x, y: pos_y, z: pos_z, final_voxel: final_voxel};

  vdc_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .cmd_valid(cmd_valid), .cmd_out(cmd), .cmd_pop(cmd_pop), .back_busy(back_busy));

  vdc_back #(.MaxVoxels(MaxVoxels), .CoordBits(CoordBits)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .back_busy(back_busy), .min_neighbors(min_neighbors),
    .max_distance_squared(max_distance_squared), .done(done),
    .voxel_index(voxel_index), .cluster_id(cluster_id),
    .cluster_count(cluster_count), .overflow(overflow), .last_result(last_result));
endmodule

// ----- tb/tb_voxel_density_clustering.sv -----
// Self-checking testbench for voxel_density_clustering: loads voxel sets, predicts
// per-voxel cluster labels and checks every done transaction. Depends on vdc_pkg and voxel_density_clustering.
`timescale 1ns / 1ps
module tb_voxel_density_clustering;
  import vdc_pkg::*;

  localparam int NVOX = 64;
  localparam int UNASSIGNED = 127;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  typedef struct {
    logic [5:0] voxel_index;
    logic [5:0] cluster_id;
    logic [6:0] cluster_count;
    logic       overflow;
    logic       last_result;
  } label_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic final_voxel = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [17:0] cfg_data = '0;
  logic done;
  logic [5:0] voxel_index, cluster_id;
  logic [6:0] cluster_count;
  logic overflow, last_result;

  voxel_density_clustering u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  int unsigned min_nbr = 1, max_dsq = 4;
  logic [7:0] px[NVOX], py[NVOX], pz[NVOX];
  int set_len = 0;
  bit set_ovf = 0;
  label_t expected_labels[$];

  vox_cmd_t pending_voxels[$];
  int errors = 0;
  bit quiet_mode = 0;
  bit fill_done = 0;
  longint cycles = 0;

  function automatic int unsigned voxel_dsq(int a, int b);
    int dx, dy, dz;
    dx = int'(px[a]) - int'(px[b]);
    dy = int'(py[a]) - int'(py[b]);
    dz = int'(pz[a]) - int'(pz[b]);
    return dx*dx + dy*dy + dz*dz;
  endfunction

  // Cluster the stored set and queue one expected label per voxel
  task automatic cluster_and_expect();
    int lbl[NVOX];
    bit marked[NVOX];
    int fifo[$];
    int cand[$];
    int n, done_cnt, next_id, o, cnt;
    n = set_len;
    done_cnt = 0;
    next_id = 0;
    for (int i = 0; i < NVOX; i++) begin
      lbl[i] = UNASSIGNED;
      marked[i] = 0;
    end
    while (done_cnt < n) begin
      if (fifo.size() == 0) begin
        for (int i = 0; i < n; i++) begin
          if (lbl[i] == UNASSIGNED) begin
            lbl[i] = next_id;
            next_id++;
            fifo = {fifo, i};
            marked[i] = 1;
            done_cnt++;
            break;
          end
        end
      end
      while (fifo.size() > 0) begin
        o = fifo[0];
        cnt = 0;
        cand.delete();
        for (int j = 0; j < n; j++) begin
          if (j != o && voxel_dsq(o, j) <= max_dsq) begin
            cnt++;
            if (lbl[j] == UNASSIGNED && !marked[j]) cand = {cand, j};
          end
        end
        if (cnt >= min_nbr) begin
          foreach (cand[k]) begin
            fifo = {fifo, cand[k]};
            marked[cand[k]] = 1;
          end
          if (lbl[o] == UNASSIGNED) begin
            lbl[o] = next_id - 1;
            done_cnt++;
          end
        end
        marked[o] = 0;
        void'(fifo.pop_front());
      end
    end
    for (int i = 0; i < n; i++) begin
      label_t e;
      e.voxel_index = i[5:0];
      e.cluster_id = lbl[i][5:0];
      e.cluster_count = next_id[6:0];
      e.overflow = set_ovf;
      e.last_result = (i + 1 == n);
      expected_labels = {expected_labels, e};
    end
    set_len = 0;
    set_ovf = 0;
  endtask

  task automatic accept_voxel(vox_cmd_t v);
    if (set_len < NVOX) begin
      px[set_len] = v.x;
      py[set_len] = v.y;
      pz[set_len] = v.z;
      set_len++;
    end else begin
      set_ovf = 1;
    end
    if (v.final_voxel) cluster_and_expect();
  endtask

  // Driver: one transaction per accepted start, random idle bursts
  int idle_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        accept_voxel('{x: pos_x, y: pos_y, z: pos_z, final_voxel: final_voxel});
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          start <= 1'b0;
        end else if (pending_voxels.size() > 0 && !quiet_mode
                     && !(start && !busy && pending_voxels.size() == 0)) begin
          vox_cmd_t v;
          v = pending_voxels.pop_front();
          pos_x <= v.x;
          pos_y <= v.y;
          pos_z <= v.z;
          final_voxel <= v.final_voxel;
          start <= 1'b1;
          if (!fill_done && $urandom_range(0, 5) == 0) idle_left <= $urandom_range(1, 4);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each done transaction with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_labels.size() == 0) begin
        $error("unexpected result: voxel_index %0d", voxel_index);
        errors++;
      end else begin
        label_t e;
        e = expected_labels.pop_front();
        if (voxel_index !== e.voxel_index) begin
          $error("voxel_index exp %0d got %0d", e.voxel_index, voxel_index); errors++;
        end
        if (cluster_id !== e.cluster_id) begin
          $error("cluster_id exp %0d got %0d", e.cluster_id, cluster_id); errors++;
        end
        if (cluster_count !== e.cluster_count) begin
          $error("cluster_count exp %0d got %0d", e.cluster_count, cluster_count); errors++;
        end
        if (overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, overflow); errors++;
        end
        if (last_result !== e.last_result) begin
          $error("last_result exp %0d got %0d", e.last_result, last_result); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Wait until driver and block are fully drained (sampled after edge updates settle)
  task automatic wait_idle();
    @(negedge clk);
    while (pending_voxels.size() > 0 || start || busy || expected_labels.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[17:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    min_nbr = (idx == REG_MIN_NEIGHBORS) ? (val & 7'h7F) : min_nbr;
    max_dsq = (idx == REG_MAX_DIST_SQ) ? (val & 18'h3FFFF) : max_dsq;
  endtask

  function automatic void add_voxel(int x, int y, int z, bit fin);
    vox_cmd_t v;
    v = '{x: x[7:0], y: y[7:0], z: z[7:0], final_voxel: fin};
    pending_voxels = {pending_voxels, v};
  endfunction

  // Random set: clumps around a few centers plus scattered noise
  function automatic void add_random_set(int n, int spread);
    int cx, cy, cz;
    for (int i = 0; i < n; i++) begin
      if (i % 5 == 0) begin
        cx = $urandom_range(0, 255); cy = $urandom_range(0, 255); cz = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 3) == 0)
        add_voxel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  i == n - 1);
      else
        add_voxel((cx + $urandom_range(0, spread)) & 255, (cy + $urandom_range(0, spread)) & 255,
                  (cz + $urandom_range(0, spread)) & 255, i == n - 1);
    end
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset config, extremes, single voxel, neighbors at the limit
    add_voxel(0, 0, 0, 1);
    add_voxel(0, 0, 0, 0);
    add_voxel(2, 0, 0, 0);
    add_voxel(255, 255, 255, 0);
    add_voxel(3, 0, 0, 0);
    add_voxel(254, 255, 255, 1);
    wait_idle();
    // zero min_neighbors, widest distance: one cluster
    write_reg(REG_MIN_NEIGHBORS, 0);
    write_reg(REG_MAX_DIST_SQ, 195075);
    add_voxel(0, 0, 0, 0);
    add_voxel(255, 255, 255, 0);
    add_voxel(170, 85, 170, 1);
    wait_idle();
    // large min_neighbors: every voxel alone
    write_reg(REG_MIN_NEIGHBORS, 64);
    write_reg(REG_MAX_DIST_SQ, 262143);
    add_random_set(6, 3);
    wait_idle();
    // capacity exceeded, final on a dropped voxel
    write_reg(REG_MIN_NEIGHBORS, 2);
    write_reg(REG_MAX_DIST_SQ, 0);
    for (int i = 0; i < 66; i++) add_voxel(i & 7, 0, (i >> 3) & 1, i == 65);
    wait_idle();

    // Random sets under several settings
    for (int s = 0; s < 22; s++) begin
      if (s % 5 == 0) begin
        // settings change only with nothing in flight
        wait_idle();
        write_reg(REG_MIN_NEIGHBORS, $urandom_range(0, 5));
        write_reg(REG_MAX_DIST_SQ, $urandom_range(0, 40));
      end
      if (s == 18) fill_done = 1;
      add_random_set((s % 10 == 9) ? $urandom_range(40, 64) : $urandom_range(1, 12), 4);
      if (s == 12) begin
        // hold off until every expected label has come
        wait_idle();
      end
    end
    wait_idle();

    if (errors == 0 && expected_labels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/vdc_pkg.sv
hdl/vdc_ram.sv
hdl/vdc_front.sv
hdl/vdc_back.sv
hdl/voxel_density_clustering.sv
tb/tb_voxel_density_clustering.sv
